>>> rtl/ntaf_pkg.sv
// shared types, constants and helpers for the number to ascii formatter
package ntaf_pkg;

  localparam int ValueW   = 64;
  localparam int BinW     = 32;
  localparam int DecDigs  = 10;
  localparam int BcdW     = 4 * DecDigs;
  localparam int CharW    = 7;

  localparam logic [2:0] KIND_DEC32 = 3'd0;
  localparam logic [2:0] KIND_HEX8  = 3'd1;
  localparam logic [2:0] KIND_HEX16 = 3'd2;
  localparam logic [2:0] KIND_HEX32 = 3'd3;
  localparam logic [2:0] KIND_AUTO  = 3'd4;

  localparam logic [CharW-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CharW-1:0] CHAR_A    = 7'h41;
  localparam logic [3:0]       NIB_TEN   = 4'hA;

  typedef struct packed {
    logic [2:0]        kind;
    logic [ValueW-1:0] value;
  } in_t;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic conv_step;
    logic skip_shift;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic kind_ok;
    logic kind_dec;
    logic conv_done;
    logic top_zero;
    logic rem_zero;
    logic out_free;
  } sts_t;

  function automatic logic [CharW-1:0] hex_char(input logic [3:0] nib);
    if (nib >= NIB_TEN) begin
      return CHAR_A + {3'b000, nib - NIB_TEN};
    end
    return CHAR_ZERO + {3'b000, nib};
  endfunction

endpackage

>>> rtl/ntaf_ctrl.sv
// sequencing state machine: load, binary to bcd steps, zero skip, emission
module ntaf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ntaf_pkg::sts_t  sts,
  output ntaf_pkg::cmd_t  cmd
);

  ntaf_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ntaf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ntaf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          // unknown kinds are taken and dropped
          if (sts.kind_ok) begin
            state_next = sts.kind_dec ? ntaf_pkg::ST_CONV : ntaf_pkg::ST_EMIT;
          end
        end
      end
      ntaf_pkg::ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_done) begin
          state_next = ntaf_pkg::ST_SKIP;
        end
      end
      ntaf_pkg::ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if (sts.top_zero && !sts.rem_zero) begin
          cmd.skip_shift = 1'b1;
        end else begin
          state_next = ntaf_pkg::ST_EMIT;
        end
      end
      ntaf_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.rem_zero) begin
            state_next = ntaf_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ntaf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/ntaf_dp.sv
// datapath: digit shift register, double dabble converter, output register
module ntaf_dp (
  input  logic            clk,
  input  logic            rst,
  input  ntaf_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ntaf_pkg::out_t  out_data,
  input  ntaf_pkg::cmd_t  cmd,
  output ntaf_pkg::sts_t  sts
);

  // digits most significant first at the top; bcd sits in the top 40 bits
  logic [ntaf_pkg::ValueW-1:0] digits;
  logic [ntaf_pkg::BinW-1:0]   bin;
  logic [4:0]                  conv_cnt;
  logic [3:0]                  rem;

  logic                        hi_zero;
  logic                        dec_sel;
  logic [ntaf_pkg::BcdW-1:0]   bcd_adj;

  assign hi_zero = (in_data.value[63:32] == '0);
  assign dec_sel = (in_data.kind == ntaf_pkg::KIND_DEC32) ||
                   ((in_data.kind == ntaf_pkg::KIND_AUTO) && hi_zero);

  always_comb begin
    for (int d = 0; d < ntaf_pkg::DecDigs; d++) begin
      bcd_adj[4*d +: 4] = digits[ntaf_pkg::ValueW-ntaf_pkg::BcdW+4*d +: 4];
      if (bcd_adj[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_adj[4*d +: 4] + 4'd3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin      <= in_data.value[31:0];
      conv_cnt <= 5'd31;
      if (dec_sel) begin
        digits <= '0;
        rem    <= 4'd9;
      end else begin
        case (in_data.kind)
          ntaf_pkg::KIND_HEX8: begin
            digits <= {in_data.value[7:0], 56'd0};
            rem    <= 4'd1;
          end
          ntaf_pkg::KIND_HEX16: begin
            digits <= {in_data.value[15:0], 48'd0};
            rem    <= 4'd3;
          end
          ntaf_pkg::KIND_HEX32: begin
            digits <= {in_data.value[31:0], 32'd0};
            rem    <= 4'd7;
          end
          default: begin
            digits <= in_data.value;
            rem    <= 4'd15;
          end
        endcase
      end
    end else if (cmd.conv_step) begin
      {digits[63:24], bin} <= {bcd_adj[38:0], bin, 1'b0};
      conv_cnt             <= conv_cnt - 5'd1;
    end else if (cmd.skip_shift || cmd.emit) begin
      digits <= {digits[59:0], 4'd0};
      rem    <= rem - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.char_code <= ntaf_pkg::hex_char(digits[63:60]);
      out_data.last      <= (rem == 4'd0);
    end
  end

  assign sts.kind_ok   = (in_data.kind <= ntaf_pkg::KIND_AUTO);
  assign sts.kind_dec  = dec_sel;
  assign sts.conv_done = (conv_cnt == 5'd0);
  assign sts.top_zero  = (digits[63:60] == 4'd0);
  assign sts.rem_zero  = (rem == 4'd0);
  assign sts.out_free  = !out_valid || out_ready;

endmodule

>>> rtl/number_to_ascii_formatter_top.sv
// top level of the number to ascii formatter
//
//  channel | signals                        | moves
//  --------+--------------------------------+------------------------------
//  in      | in_valid, in_ready, in_data    | one number and format kind
//  out     | out_valid, out_ready, out_data | one ascii character + last
//
// hex kinds: a load, then one character per cycle while out is not stalled.
// decimal: a load, 32 double dabble steps, zero skips that drop up to 9
// leading zeros, then 1 to 10 characters; skipped zeros and characters
// always add to 10.
// one item is worked on at a time; in_ready is high only between items.
// reset clears the state machine and the output valid; out stalls hold the
// emission and the digit register.
module number_to_ascii_formatter_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ntaf_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ntaf_pkg::out_t  out_data
);

  ntaf_pkg::cmd_t cmd;
  ntaf_pkg::sts_t sts;

  ntaf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ntaf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

  // unknown kinds leave the block free for the next item
  a_bad_kind_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.kind > ntaf_pkg::KIND_AUTO) |=> in_ready)
    else $error("block busy after an unknown kind");

  // a hex8 number, once taken, makes the block busy
  a_hex_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.kind == ntaf_pkg::KIND_HEX8) |=> !in_ready)
    else $error("hex8 item not taken up");

  // only digits and uppercase hex letters come out
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      ((out_data.char_code >= 7'h30) && (out_data.char_code <= 7'h39)) ||
      ((out_data.char_code >= 7'h41) && (out_data.char_code <= 7'h46)))
    else $error("character out of range");

endmodule
